// ----- design/ovl_pkg.sv -----
`default_nettype none

package ovl_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_DELETE = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_DEL_MISS  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_COMPARE = 2'd1,
        S_APPLY   = 2'd2
    } t_state;

    typedef struct packed {
        logic               [1:0]       kind;
        logic signed        [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic [6:0]         entry_count;
    } t_out;

    typedef struct packed {
        logic compare;
        logic insert;
        logic delete_op;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ----- design/ovl_cell.sv -----
`default_nettype none

module ovl_cell (
    input  logic                    i_clk,
    input  logic [ovl_pkg::IDX_W-1:0] i_idx,
    input  logic [ovl_pkg::CNT_W-1:0] i_count,
    input  ovl_pkg::t_cell_cmd      i_cmd,
    input  logic [ovl_pkg::VAL_W-1:0] i_key,
    input  logic [ovl_pkg::VAL_W-1:0] i_right_val,
    input  logic                    i_seen,
    output logic [ovl_pkg::VAL_W-1:0] o_val,
    output logic                    o_seen
);
    import ovl_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic             r_match;
    logic [CNT_W-1:0] pos;
    logic             occupied;

    assign pos      = CNT_W'(i_idx);
    assign occupied = (pos < i_count);
    assign o_seen   = i_seen | r_match;
    assign o_val    = r_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_match <= occupied && (r_val == i_key);
        end
        if (i_cmd.insert && (pos == i_count)) begin
            r_val <= i_key;
        end else if (i_cmd.delete_op && o_seen) begin
            r_val <= i_right_val;
        end
    end

endmodule

`default_nettype wire

// ----- design/ovl_ctrl.sv -----
`default_nettype none

module ovl_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  ovl_pkg::t_in              i_item,
    input  logic                      i_found,
    output logic                      busy,
    output ovl_pkg::t_cell_cmd        o_cmd,
    output logic [ovl_pkg::VAL_W-1:0] o_key,
    output logic [ovl_pkg::CNT_W-1:0] o_count,
    output logic                      o_done,
    output ovl_pkg::t_out             o_result
);
    import ovl_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [1:0]       r_kind;
    logic [VAL_W-1:0] r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_status          n_status;
    t_out             r_result;
    logic             r_done;
    logic             accept;
    logic             full;

    assign accept = start && !busy;
    assign full   = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    n_state = start ? S_COMPARE : S_IDLE;
            S_COMPARE: n_state = S_APPLY;
            S_APPLY:   n_state = start ? S_COMPARE : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy            = (r_state == S_COMPARE);
        o_cmd.compare   = (r_state == S_COMPARE);
        o_cmd.insert    = (r_state == S_APPLY) && (r_kind == KIND_INSERT) && !full;
        o_cmd.delete_op = (r_state == S_APPLY) && (r_kind == KIND_DELETE);
    end

    always_comb begin
        n_count = r_count;
        unique case (r_kind)
            KIND_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            KIND_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!i_found) begin
                    n_status = ST_DEL_MISS;
                end else begin
                    n_status = ST_DELETED;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: n_status = i_found ? ST_FOUND : ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_APPLY);
            if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_item.kind;
            r_key  <= i_item.value;
        end
        if (r_state == S_APPLY) begin
            r_result.status      <= n_status;
            r_result.entry_count <= 7'(n_count);
        end
    end

    assign o_key    = r_key;
    assign o_count  = r_count;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- design/ordered_value_list.sv -----
// An item runs through the compare and apply states; the result and o_done are
// registered in apply. busy is high in compare only; apply can accept a new item.
// Each cell compares its entry in the compare cycle, then the match chain and the
// shift or insert are resolved in the apply cycle.
// Synchronous active-low reset empties the list; the receiver cannot stall results.
`default_nettype none

module ordered_value_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ovl_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_done,
    output ovl_pkg::t_out o_result
);
    import ovl_pkg::*;

    t_cell_cmd        cmd;
    logic [VAL_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] vals  [CAPACITY];
    logic [VAL_W-1:0] right [CAPACITY];
    logic             seen  [CAPACITY+1];

    assign seen[0] = 1'b0;

    ovl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .i_found  (seen[CAPACITY]),
        .busy     (busy),
        .o_cmd    (cmd),
        .o_key    (key),
        .o_count  (count),
        .o_done   (o_done),
        .o_result (o_result)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_last
            assign right[g] = '0;
        end else begin : g_mid
            assign right[g] = vals[g+1];
        end

        ovl_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (IDX_W'(g)),
            .i_count     (count),
            .i_cmd       (cmd),
            .i_key       (key),
            .i_right_val (right[g]),
            .i_seen      (seen[g]),
            .o_val       (vals[g]),
            .o_seen      (seen[g+1])
        );
    end

endmodule

`default_nettype wire

// ----- design/ovl_checker.sv -----
`default_nettype none

module ovl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input ovl_pkg::t_in  i_item,
    input logic          busy,
    input logic          o_done,
    input ovl_pkg::t_out o_result
);
    import ovl_pkg::*;

    logic accept;

    assign accept = start && !busy && i_rst_n;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_done)
        else $error("accepted item produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3))
        else $error("result without an accepted item");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_INSERTED || o_result.status == ST_DELETED))
        |-> !(o_result.status == ST_DELETED && $past(i_item.kind, 3) != KIND_DELETE))
        else $error("delete status for an item that was not a delete");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

// ----- tb/sv/ordered_value_list_tb.sv -----
`default_nettype none

module ordered_value_list_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ovl_pkg::*;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         RANDOM_ITEMS = 750;

    typedef struct {
        t_in         item;
        int unsigned gap_after;
        bit          hold_for_drain;
    } t_pending_op;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_in   i_item = '0;
    logic  busy;
    logic  o_done;
    t_out  o_result;

    t_pending_op             pending_ops[$];
    t_out                    expected_results[$];
    logic signed [VAL_W-1:0] list_model[$];
    logic signed [VAL_W-1:0] inserted_history[$];

    int unsigned gap_left = 0;
    int          ops_accepted = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    ordered_value_list u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_out apply_to_list(t_in op);
        t_out r;
        int   hit;
        int   i;
        hit = -1;
        for (i = 0; i < list_model.size(); i++) begin
            if (hit < 0 && list_model[i] == op.value) begin
                hit = i;
            end
        end
        if (op.kind == KIND_INSERT) begin
            if (list_model.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                list_model.push_back(op.value);
                r.status = ST_INSERTED;
            end
        end else if (op.kind == KIND_DELETE) begin
            if (list_model.size() == 0) begin
                r.status = ST_EMPTY;
            end else if (hit < 0) begin
                r.status = ST_DEL_MISS;
            end else begin
                list_model.delete(hit);
                r.status = ST_DELETED;
            end
        end else begin
            r.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
        end
        r.entry_count = 7'(list_model.size());
        return r;
    endfunction

    task automatic queue_op(logic [1:0] kind, logic signed [VAL_W-1:0] value,
                            int unsigned gap_after, bit hold_for_drain);
        t_pending_op p;
        p.item.kind      = kind;
        p.item.value     = value;
        p.gap_after      = gap_after;
        p.hold_for_drain = hold_for_drain;
        pending_ops.push_back(p);
        if (kind == KIND_INSERT) begin
            inserted_history.push_back(value);
            if (inserted_history.size() > 64) begin
                void'(inserted_history.pop_front());
            end
        end
    endtask

    function automatic int unsigned pick_gap(bit no_idle);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return $signed(32'($urandom_range(0, 15))) - 32'sd8;
        end else if (roll < 70 && inserted_history.size() != 0) begin
            return inserted_history[$urandom_range(0, inserted_history.size() - 1)];
        end
        return $signed($urandom);
    endfunction

    function automatic logic [1:0] pick_kind(int unsigned mode);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            return KIND_SPARE;
        end
        case (mode)
            0: begin
                return (roll < 85) ? KIND_INSERT : ((roll < 93) ? KIND_SEARCH : KIND_DELETE);
            end
            1: begin
                return (roll < 70) ? KIND_DELETE : ((roll < 85) ? KIND_SEARCH : KIND_INSERT);
            end
            default: begin
                return (roll < 40) ? KIND_INSERT : ((roll < 70) ? KIND_SEARCH : KIND_DELETE);
            end
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        logic sending;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            sending = start;
            if (start && !busy) begin
                expected_results.push_back(apply_to_list(i_item));
                ops_accepted <= ops_accepted + 1;
                sending = 1'b0;
            end
            if (!sending) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end else if (pending_ops.size() != 0 &&
                             !(pending_ops[0].hold_for_drain &&
                               (start || ops_accepted != results_seen))) begin
                    i_item   <= pending_ops[0].item;
                    gap_left <= pending_ops[0].gap_after;
                    start    <= 1'b1;
                    void'(pending_ops.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected item: status %0d count %0d",
                                        o_result.status, o_result.entry_count));
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    note_mismatch($sformatf("status expected %0d actual %0d",
                                            want.status, o_result.status));
                end
                if (o_result.entry_count !== want.entry_count) begin
                    note_mismatch($sformatf("entry_count expected %0d actual %0d",
                                            want.entry_count, o_result.entry_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int          generated;
        int unsigned mode;
        int unsigned block_len;
        bit          no_idle;
        int          k;

        queue_op(KIND_SEARCH, 32'sd0, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sd5, 1, 1'b0);
        queue_op(KIND_SPARE, 32'sd0, 0, 1'b0);
        queue_op(KIND_INSERT, 32'sh8000_0000, 0, 1'b0);
        queue_op(KIND_INSERT, 32'sh7FFF_FFFF, 2, 1'b0);
        queue_op(KIND_INSERT, 32'sd0, 0, 1'b0);
        queue_op(KIND_INSERT, -32'sd1, 0, 1'b0);
        queue_op(KIND_INSERT, 32'sd7, 0, 1'b0);
        queue_op(KIND_INSERT, 32'sd7, 3, 1'b0);
        queue_op(KIND_SEARCH, 32'sh7FFF_FFFF, 0, 1'b0);
        queue_op(KIND_SEARCH, 32'sh8000_0000, 0, 1'b0);
        queue_op(KIND_SEARCH, 32'sd12345, 1, 1'b0);
        queue_op(KIND_SPARE, -32'sd1, 0, 1'b0);
        queue_op(KIND_SPARE, 32'sh5555_5555, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sd99, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sd7, 0, 1'b0);
        queue_op(KIND_SEARCH, 32'sd7, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sd0, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sh8000_0000, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sd7, 0, 1'b0);
        queue_op(KIND_DELETE, -32'sd1, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sh7FFF_FFFF, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sh7FFF_FFFF, 0, 1'b0);
        queue_op(KIND_DELETE, 32'sd1, 0, 1'b0);

        generated = 0;
        while (generated < RANDOM_ITEMS) begin
            mode      = $urandom_range(0, 2);
            block_len = $urandom_range(30, 90);
            no_idle   = ($urandom_range(0, 3) == 0);
            for (k = 0; k < block_len && generated < RANDOM_ITEMS; k++) begin
                queue_op(pick_kind(mode), pick_value(), pick_gap(no_idle),
                         (generated == 0) || ($urandom_range(0, 99) == 0));
                generated++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_ops.size() != 0 || start || ops_accepted != results_seen) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
